// ----- rtl/sap_pkg.sv -----
// Shared types, constants and helper functions for the shelf atlas slot packer.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package sap_pkg;

  // Field widths of the words on the channels and of the configuration registers.
  localparam int unsigned SPECIES_W = 16;
  localparam int unsigned DIM_W     = 15;
  localparam int unsigned STEPS_W   = 8;
  localparam int unsigned SLOT_W_W  = DIM_W + STEPS_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATLAS   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0]    CELL_SIZE_RST   = 15'd128;
  localparam logic [STEPS_W-1:0]  ANGLE_STEPS_RST = 8'd8;
  localparam logic [DIM_W-1:0]    MAX_ATLAS_RST   = 15'd4096;
  localparam logic [SLOT_W_W-1:0] SLOT_W_RST      = 23'd1024;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_CFG = 2'd2
  } sap_status_t;

  // Round a 15-bit extent up to the next power of two; zero and one give one.
  function automatic logic [DIM_W:0] next_pow2(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] x;
    x = v - 15'd1;
    x = x | (x >> 1);
    x = x | (x >> 2);
    x = x | (x >> 4);
    x = x | (x >> 8);
    if (v <= 15'd1) begin
      return 16'd1;
    end
    return {1'b0, x} + 16'd1;
  endfunction

endpackage

// ----- rtl/sap_in_if.sv -----
// Input channel of the slot packer: valid/ready handshake carrying one species word.
// Depends on sap_pkg for field widths.
interface sap_in_if;
  logic                          valid;
  logic                          ready;
  logic [sap_pkg::SPECIES_W-1:0] species_index;
  logic                          last_in_list;

  modport source (output valid, output species_index, output last_in_list, input ready);
  modport sink   (input valid, input species_index, input last_in_list, output ready);
endinterface

// ----- rtl/sap_out_if.sv -----
// Result channel of the slot packer: valid/ready handshake carrying one placement word.
// Depends on sap_pkg for field widths.
interface sap_out_if;
  logic                          valid;
  logic                          ready;
  logic [sap_pkg::SPECIES_W-1:0] species_echo;
  logic [1:0]                    status;
  logic [sap_pkg::DIM_W-1:0]     slot_x;
  logic [sap_pkg::DIM_W-1:0]     slot_y;
  logic [sap_pkg::DIM_W-1:0]     atlas_width;
  logic [sap_pkg::DIM_W-1:0]     atlas_height;
  logic                          last_out;

  modport source (output valid, output species_echo, output status, output slot_x,
                  output slot_y, output atlas_width, output atlas_height,
                  output last_out, input ready);
  modport sink   (input valid, input species_echo, input status, input slot_x,
                  input slot_y, input atlas_width, input atlas_height,
                  input last_out, output ready);
endinterface

// ----- rtl/shelf_atlas_slot_packer_unit.sv -----
// Top level of the shelf atlas slot packer: row-major placement of equal slots.
// Depends on sap_pkg, sap_in_if and sap_out_if.
//
//   channel  | direction | handshake           | word
//   ---------+-----------+---------------------+-------------------------------------
//   in_ch    | in        | valid/ready         | species_index, last_in_list
//   out_ch   | out       | valid/ready         | species_echo, status, slot, sizes, last
//   cfg_*    | in        | write enable only   | register index, write data
//
// Each word is placed combinationally: the cursor compares and adds, the size rounding
// and the state update sit between the input port and the result register.
// A new word is taken every cycle while the result register is empty or being drained.
// When the result side stalls, the result register holds and in_ch.ready drops.
// Reset (synchronous, rst_n low) clears the cursors, extents and the full flag, and
// loads the default configuration. The list state also clears after each last word.
module shelf_atlas_slot_packer_unit #(
  parameter int unsigned MAX_ATLAS_DIM = 16384
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sap_in_if.sink                          in_ch,
  sap_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [sap_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sap_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  localparam int unsigned DW = sap_pkg::DIM_W;

  // Configuration registers and the slot width derived from them.
  logic [DW-1:0]                   cell_size_r;
  logic [sap_pkg::STEPS_W-1:0]     angle_steps_r;
  logic [DW-1:0]                   max_atlas_r;
  logic [sap_pkg::SLOT_W_W-1:0]    slot_w_r;
  logic [DW-1:0]                   mul_a;
  logic [sap_pkg::STEPS_W-1:0]     mul_b;
  logic [sap_pkg::SLOT_W_W-1:0]    mul_p;

  // List state.
  logic [DW-1:0] col_r, col_nxt;
  logic [DW-1:0] row_r, row_nxt;
  logic [DW-1:0] used_w_r, used_w_nxt;
  logic [DW-1:0] used_h_r, used_h_nxt;
  logic          full_r, full_nxt;

  // Result register.
  logic                          out_valid_r, out_valid_nxt;
  logic [sap_pkg::SPECIES_W-1:0] species_r;
  sap_pkg::sap_status_t          status_r, status_nxt;
  logic [DW-1:0]                 slot_x_r, slot_x_nxt;
  logic [DW-1:0]                 slot_y_r, slot_y_nxt;
  logic [DW-1:0]                 aw_r, aw_nxt;
  logic [DW-1:0]                 ah_r, ah_nxt;
  logic                          last_r;

  // Datapath temporaries.
  logic          in_fire;
  logic          bad_cfg;
  logic [DW-1:0] slot_w15;
  logic          wrap;
  logic [DW-1:0] col_a, row_a;
  logic [DW:0]   row_end;
  logic [DW:0]   col_end;
  logic          over;
  logic [DW-1:0] h_ext;
  logic [DW:0]   pw_w, pw_h;

  // The slot width product is refreshed at the same edge as the register it depends on.
  assign mul_a = (cfg_index == sap_pkg::CFG_CELL_SIZE) ? cfg_wdata : cell_size_r;
  assign mul_b = (cfg_index == sap_pkg::CFG_ANGLE_STEPS) ? cfg_wdata[sap_pkg::STEPS_W-1:0]
                                                           : angle_steps_r;
  assign mul_p = sap_pkg::SLOT_W_W'(mul_a) * sap_pkg::SLOT_W_W'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r   <= sap_pkg::CELL_SIZE_RST;
      angle_steps_r <= sap_pkg::ANGLE_STEPS_RST;
      max_atlas_r   <= sap_pkg::MAX_ATLAS_RST;
      slot_w_r      <= sap_pkg::SLOT_W_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sap_pkg::CFG_CELL_SIZE: begin
          cell_size_r <= cfg_wdata;
          slot_w_r    <= mul_p;
        end
        sap_pkg::CFG_ANGLE_STEPS: begin
          angle_steps_r <= cfg_wdata[sap_pkg::STEPS_W-1:0];
          slot_w_r      <= mul_p;
        end
        sap_pkg::CFG_MAX_ATLAS: begin
          max_atlas_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake: the result register parts the two sides.
  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_valid_nxt = in_fire || (out_valid_r && !out_ch.ready);

  // Configuration check.
  assign bad_cfg = (cell_size_r == '0) || (angle_steps_r == '0) || (max_atlas_r == '0) ||
                   ({17'd0, max_atlas_r} > 32'(MAX_ATLAS_DIM)) ||
                   (slot_w_r > {8'd0, max_atlas_r});
  assign slot_w15 = slot_w_r[DW-1:0];

  // Placement: wrap to the next row when the slot would pass the right edge.
  assign wrap    = ({1'b0, col_r} + {1'b0, slot_w15}) > {1'b0, max_atlas_r};
  assign col_a   = wrap ? '0 : col_r;
  assign row_a   = wrap ? DW'(row_r + cell_size_r) : row_r;
  assign row_end = {1'b0, row_a} + {1'b0, cell_size_r};
  assign over    = row_end > {1'b0, max_atlas_r};
  assign col_end = {1'b0, col_a} + {1'b0, slot_w15};

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    used_w_nxt = used_w_r;
    used_h_nxt = used_h_r;
    full_nxt   = full_r;
    slot_x_nxt = '0;
    slot_y_nxt = '0;
    if (!full_r) begin
      col_nxt = col_a;
      row_nxt = row_a;
      if (over) begin
        full_nxt = 1'b1;
      end else begin
        slot_x_nxt = col_a;
        slot_y_nxt = row_a;
        col_nxt    = col_end[DW-1:0];
        if (col_end[DW-1:0] > used_w_r) begin
          used_w_nxt = col_end[DW-1:0];
        end
        if (row_end > {1'b0, used_h_r}) begin
          used_h_nxt = row_end[DW-1:0];
        end
      end
    end
  end

  // Running atlas size: extents rounded up to a power of two, capped at the maximum.
  assign h_ext = (used_h_nxt > cell_size_r) ? used_h_nxt : cell_size_r;
  assign pw_w  = sap_pkg::next_pow2(used_w_nxt);
  assign pw_h  = sap_pkg::next_pow2(h_ext);

  always_comb begin
    if (bad_cfg) begin
      status_nxt = sap_pkg::ST_BAD_CFG;
      aw_nxt     = '0;
      ah_nxt     = '0;
    end else begin
      status_nxt = full_nxt ? sap_pkg::ST_FULL : sap_pkg::ST_PLACED;
      aw_nxt     = (pw_w < {1'b0, max_atlas_r}) ? pw_w[DW-1:0] : max_atlas_r;
      ah_nxt     = (pw_h < {1'b0, max_atlas_r}) ? pw_h[DW-1:0] : max_atlas_r;
    end
  end

  // Control state: list state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      used_w_r    <= '0;
      used_h_r    <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        if (in_ch.last_in_list) begin
          col_r    <= '0;
          row_r    <= '0;
          used_w_r <= '0;
          used_h_r <= '0;
          full_r   <= 1'b0;
        end else if (!bad_cfg) begin
          col_r    <= col_nxt;
          row_r    <= row_nxt;
          used_w_r <= used_w_nxt;
          used_h_r <= used_h_nxt;
          full_r   <= full_nxt;
        end
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      species_r <= in_ch.species_index;
      status_r  <= status_nxt;
      slot_x_r  <= bad_cfg ? '0 : slot_x_nxt;
      slot_y_r  <= bad_cfg ? '0 : slot_y_nxt;
      aw_r      <= aw_nxt;
      ah_r      <= ah_nxt;
      last_r    <= in_ch.last_in_list;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.species_echo = species_r;
  assign out_ch.status       = status_r;
  assign out_ch.slot_x       = slot_x_r;
  assign out_ch.slot_y       = slot_y_r;
  assign out_ch.atlas_width  = aw_r;
  assign out_ch.atlas_height = ah_r;
  assign out_ch.last_out     = last_r;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for shelf_atlas_slot_packer_unit: row-major slot placement.
// Depends on sap_pkg, sap_in_if and sap_out_if; predicts every result word and compares
// it field by field under random idling on both channels.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ATLAS_DIM_LIMIT = 16384;
  localparam int unsigned RANDOM_WORDS    = 700;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned LONG_HOLD       = 300;

  typedef struct packed {
    logic [sap_pkg::SPECIES_W-1:0] species;
    logic                          last;
  } species_word_t;

  typedef struct packed {
    logic [sap_pkg::SPECIES_W-1:0] species;
    sap_pkg::sap_status_t          status;
    logic [sap_pkg::DIM_W-1:0]     slot_x;
    logic [sap_pkg::DIM_W-1:0]     slot_y;
    logic [sap_pkg::DIM_W-1:0]     atlas_w;
    logic [sap_pkg::DIM_W-1:0]     atlas_h;
    logic                          last;
  } placement_t;

  logic clk;
  logic rst_n;
  logic                          cfg_we;
  logic [sap_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sap_pkg::CFG_DAT_W-1:0] cfg_wdata;

  sap_in_if  in_ch ();
  sap_out_if out_ch ();

  shelf_atlas_slot_packer_unit #(
    .MAX_ATLAS_DIM(ATLAS_DIM_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Configuration as the block holds it, and the list state of the packer.
  int unsigned cell_sz = 32'(sap_pkg::CELL_SIZE_RST);
  int unsigned steps   = 32'(sap_pkg::ANGLE_STEPS_RST);
  int unsigned max_sz  = 32'(sap_pkg::MAX_ATLAS_RST);
  int unsigned col_q   = 0;
  int unsigned row_q   = 0;
  int unsigned used_w  = 0;
  int unsigned used_h  = 0;
  bit          full_q  = 1'b0;

  species_word_t species_backlog[$];
  placement_t    placements_due[$];
  int unsigned   n_pushed   = 0;
  int unsigned   n_accepted = 0;
  int unsigned   mismatches = 0;
  int unsigned   send_idle_pct = 10;
  int unsigned   recv_idle_pct = 78;
  bit            hold_req   = 1'b0;
  int unsigned   hold_left  = 0;
  bit            in_taken   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Smallest power of two that is not below v; zero gives one.
  function automatic int unsigned ceil_pow2(int unsigned v);
    int unsigned p;
    p = 1;
    while (p < v) p = p << 1;
    return p;
  endfunction

  // Place one species in the current list and return the result word it causes.
  function automatic placement_t place_species(logic [sap_pkg::SPECIES_W-1:0] sp, logic lst);
    placement_t  r;
    int unsigned slot_w;
    int unsigned hgt;
    int unsigned aw;
    int unsigned ah;
    slot_w    = cell_sz * steps;
    r.species = sp;
    r.status  = sap_pkg::ST_PLACED;
    r.slot_x  = '0;
    r.slot_y  = '0;
    r.atlas_w = '0;
    r.atlas_h = '0;
    r.last    = lst;
    if (cell_sz == 0 || steps == 0 || max_sz == 0 || max_sz > ATLAS_DIM_LIMIT ||
        slot_w > max_sz) begin
      r.status = sap_pkg::ST_BAD_CFG;
    end else begin
      if (!full_q) begin
        // Wrap to a new shelf when the slot would pass the right edge.
        if (col_q + slot_w > max_sz) begin
          col_q = 0;
          row_q = (row_q + cell_sz) & 32'h7FFF;
        end
        if (row_q + cell_sz > max_sz) begin
          full_q = 1'b1;
        end else begin
          r.slot_x = col_q[sap_pkg::DIM_W-1:0];
          r.slot_y = row_q[sap_pkg::DIM_W-1:0];
          col_q    = (col_q + slot_w) & 32'h7FFF;
          if (col_q > used_w) used_w = col_q;
          if (row_q + cell_sz > used_h) used_h = (row_q + cell_sz) & 32'h7FFF;
        end
      end
      r.status = full_q ? sap_pkg::ST_FULL : sap_pkg::ST_PLACED;
      // The height always counts at least one shelf.
      hgt = (used_h > cell_sz) ? used_h : cell_sz;
      aw  = ceil_pow2(used_w);
      ah  = ceil_pow2(hgt);
      if (aw > max_sz) aw = max_sz;
      if (ah > max_sz) ah = max_sz;
      r.atlas_w = aw[sap_pkg::DIM_W-1:0];
      r.atlas_h = ah[sap_pkg::DIM_W-1:0];
    end
    if (lst) begin
      col_q  = 0;
      row_q  = 0;
      used_w = 0;
      used_h = 0;
      full_q = 1'b0;
    end
    return r;
  endfunction

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Write one register; the block sees it at the next rising edge.
  task automatic wr_reg(logic [sap_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[sap_pkg::CFG_DAT_W-1:0];
    case (idx)
      sap_pkg::CFG_CELL_SIZE:   cell_sz = val & 32'h7FFF;
      sap_pkg::CFG_ANGLE_STEPS: steps   = val & 32'hFF;
      sap_pkg::CFG_MAX_ATLAS:   max_sz  = val & 32'h7FFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(int unsigned cs, int unsigned st, int unsigned mx);
    wr_reg(sap_pkg::CFG_CELL_SIZE, cs);
    wr_reg(sap_pkg::CFG_ANGLE_STEPS, st);
    wr_reg(sap_pkg::CFG_MAX_ATLAS, mx);
  endtask

  // Append one word to the sender's backlog.
  task automatic push_item(logic [sap_pkg::SPECIES_W-1:0] sp, logic lst);
    species_word_t w;
    w.species = sp;
    w.last    = lst;
    species_backlog.insert(species_backlog.size(), w);
    n_pushed++;
  endtask

  // Hold off until every word has been taken and every result has come back.
  task automatic drain();
    while (n_accepted != n_pushed || placements_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sender: offers the next backlog word, holding it until it is taken.
  always @(negedge clk) begin
    species_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (species_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        w = species_backlog.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.species_index <= w.species;
        in_ch.last_in_list  <= w.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, or a long hold when one is requested.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on every accepted word and checks every result word.
  always @(posedge clk) begin
    placement_t want;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      placements_due.insert(placements_due.size(),
                            place_species(in_ch.species_index, in_ch.last_in_list));
      n_accepted++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (placements_due.size() == 0) begin
        $error("result word with nothing pending: species_echo %0d", out_ch.species_echo);
        mismatches++;
      end else begin
        want = placements_due.pop_front();
        cmp_field("species_echo", want.species, out_ch.species_echo);
        cmp_field("status", 16'(want.status), 16'(out_ch.status));
        cmp_field("slot_x", 16'(want.slot_x), 16'(out_ch.slot_x));
        cmp_field("slot_y", 16'(want.slot_y), 16'(out_ch.slot_y));
        cmp_field("atlas_width", 16'(want.atlas_w), 16'(out_ch.atlas_width));
        cmp_field("atlas_height", 16'(want.atlas_h), 16'(out_ch.atlas_height));
        cmp_field("last_out", 16'(want.last), 16'(out_ch.last_out));
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned cs;
    int unsigned st;
    int unsigned mx;
    int unsigned spr;
    int unsigned k;
    int unsigned n_directed;
    int unsigned progress;
    int unsigned list_left;
    int unsigned phase;
    logic [sap_pkg::SPECIES_W-1:0] sp;
    logic lst;
    bit late_hold;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = sap_pkg::CFG_CELL_SIZE;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.species_index = '0;
    in_ch.last_in_list  = 1'b0;
    out_ch.ready        = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Default configuration straight out of reset.
    push_item(16'h0000, 1'b0);
    push_item(16'hFFFF, 1'b1);
    drain();

    // Two slots per shelf, four shelves: wrap, fill, drop, and a fresh list after it.
    set_config(16, 2, 64);
    for (int i = 0; i < 10; i++) push_item(16'(i * 4097), i == 9);
    push_item(16'h5A5A, 1'b1);
    drain();

    // Invalid settings: each zero register, a maximum over the limit, slots too wide.
    set_config(16, 0, 64);
    push_item(16'd1, 1'b0);
    drain();
    set_config(0, 2, 64);
    push_item(16'd2, 1'b1);
    drain();
    set_config(16, 2, 0);
    push_item(16'd3, 1'b0);
    drain();
    set_config(16, 2, ATLAS_DIM_LIMIT + 1);
    push_item(16'd4, 1'b0);
    drain();
    set_config(32767, 1, ATLAS_DIM_LIMIT);
    push_item(16'd5, 1'b1);
    drain();
    set_config(40, 2, 64);
    push_item(16'd6, 1'b1);
    drain();

    // Extremes: one slot filling the largest atlas, widest slot, one-texel atlas.
    set_config(ATLAS_DIM_LIMIT, 1, ATLAS_DIM_LIMIT);
    push_item(16'd7, 1'b0);
    push_item(16'd8, 1'b1);
    drain();
    set_config(64, 255, ATLAS_DIM_LIMIT);
    push_item(16'd9, 1'b1);
    drain();
    set_config(1, 1, 1);
    push_item(16'd10, 1'b0);
    push_item(16'd11, 1'b0);
    push_item(16'd12, 1'b1);
    drain();

    // Random phases: a new setting each phase, lists of up to forty words.
    n_directed = n_pushed;
    list_left  = 0;
    phase      = 0;
    late_hold  = 1'b0;
    while (n_pushed < n_directed + RANDOM_WORDS) begin
      progress = n_pushed - n_directed;
      if (progress < RANDOM_WORDS / 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 78;
      end else if (progress < 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 78;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      k = $urandom_range(0, 9);
      if (k == 0) begin
        cs = $urandom_range(0, 32767);
        st = $urandom_range(0, 255);
        mx = $urandom_range(0, 32767);
      end else if (k == 1) begin
        mx = ATLAS_DIM_LIMIT;
        cs = $urandom_range(0, 1) ? ATLAS_DIM_LIMIT : $urandom_range(1, 64);
        st = $urandom_range(0, 1) ? 255 : 1;
      end else begin
        // Well-formed: a few shelves of a few slots each.
        mx  = $urandom_range(1, ATLAS_DIM_LIMIT);
        cs  = mx / $urandom_range(1, 8);
        if (cs == 0) cs = 1;
        spr = $urandom_range(1, 6);
        st  = mx / (cs * spr);
        if (st == 0) st = 1;
        if (st > 255) st = 255;
      end
      set_config(cs, st, mx);

      repeat ($urandom_range(10, 60)) begin
        if (list_left == 0) list_left = $urandom_range(1, 40);
        list_left--;
        k = $urandom_range(0, 19);
        if (k == 0) sp = 16'h0000;
        else if (k == 1) sp = 16'hFFFF;
        else sp = 16'($urandom_range(0, 65535));
        // Now and then the list end falls in the wrong place.
        if ($urandom_range(0, 29) == 0) lst = (list_left != 0);
        else lst = (list_left == 0);
        push_item(sp, lst);
      end

      // Long receiver holds while the sender keeps offering words.
      if (phase == 2) begin
        hold_req = 1'b1;
      end else if (progress >= 2 * RANDOM_WORDS / 3 && !late_hold) begin
        hold_req  = 1'b1;
        late_hold = 1'b1;
      end
      drain();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sap_pkg.sv
rtl/sap_in_if.sv
rtl/sap_out_if.sv
rtl/shelf_atlas_slot_packer_unit.sv
sim/testbench.sv
